/* rtl/ahcfp_pkg.sv */
// Shared types and constants for the ASCII-hex CAN frame parser.
package ahcfp_pkg;

    localparam logic [7:0] CH_START = 8'h25;  // '%'
    localparam logic [7:0] CH_END   = 8'h23;  // '#'
    localparam logic [7:0] CH_SEP   = 8'h26;  // '&'
    localparam logic [7:0] BYTE_MASK = 8'hff;

    localparam int unsigned DATA_MAX = 8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LONG     = 3'd1;
    localparam logic [2:0] ST_BAD_ID   = 3'd2;
    localparam logic [2:0] ST_BAD_DATA = 3'd3;
    localparam logic [2:0] ST_BAD_CHK  = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nib;
        logic       is_start;
        logic       is_end;
        logic       is_sep;
    } t_char;

endpackage

/* rtl/ascii_hex_can_frame_parser.sv */
// ASCII-hex CAN frame parser: one received character per cycle unless o_rx_stall holds it, one result per frame.
// A result is registered onto o_frame_valid in the cycle after its closing item is taken.
// One character item is taken per cycle while o_rx_stall is low; the parse state updates on every accepted item.
// o_rx_stall rises only when a frame-ending item arrives while the held result is stalled.
// Reset (i_rst_n low, synchronous): parser hunts for '%', counters clear, no result held.
// The data byte store is not cleared; only bytes written in the current frame are shown.
module ascii_hex_can_frame_parser #(
    parameter int FRAME_MAX = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_frame_valid,
    input  logic        i_frame_stall,
    output logic [15:0] o_frame_id,
    output logic [3:0]  o_byte_count,
    output logic [7:0]  o_data_0,
    output logic [7:0]  o_data_1,
    output logic [7:0]  o_data_2,
    output logic [7:0]  o_data_3,
    output logic [7:0]  o_data_4,
    output logic [7:0]  o_data_5,
    output logic [7:0]  o_data_6,
    output logic [7:0]  o_data_7,
    output logic [2:0]  o_status
);
    import ahcfp_pkg::*;

    localparam int LEN_W = $clog2(FRAME_MAX);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(FRAME_MAX - 1);

    typedef enum logic [2:0] {
        PH_HUNT, PH_ID, PH_DATA, PH_CHK, PH_TAIL
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic [15:0]      r_id, n_id;
    logic [7:0]       r_data [DATA_MAX];
    logic [3:0]       r_cnt, n_cnt;
    logic [3:0]       r_hi, n_hi;
    logic [1:0]       r_dig, n_dig;
    logic [7:0]       r_sum, n_sum;
    logic [2:0]       r_err, n_err;

    logic             r_ovalid;
    logic [15:0]      r_oid;
    logic [3:0]       r_ocnt;
    logic [7:0]       r_odata [DATA_MAX];
    logic [2:0]       r_ostat;

    t_char            cls;
    logic             accept;
    logic             ends;
    logic [2:0]       end_stat;
    logic             wr_en;
    logic [7:0]       pair_byte;

    ahcfp_char_dec u_dec (
        .i_char (i_rx_byte),
        .o_cls  (cls)
    );

    assign ends       = (r_phase != PH_HUNT) && ((r_len >= LEN_LAST) || cls.is_end);
    assign o_rx_stall = r_ovalid && i_frame_stall && ends;
    assign accept     = i_rx_valid && !o_rx_stall;
    assign pair_byte  = {r_hi, cls.nib};

    always_comb begin
        if (r_len >= LEN_LAST) begin
            end_stat = ST_LONG;
        end else if (r_err != ST_OK) begin
            end_stat = r_err;
        end else begin
            unique case (r_phase)
                PH_ID:   end_stat = ST_BAD_ID;
                PH_DATA: end_stat = ST_BAD_DATA;
                PH_CHK:  end_stat = ST_BAD_CHK;
                default: end_stat = (r_sum == 8'h00) ? ST_OK : ST_MISMATCH;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_id    = r_id;
        n_cnt   = r_cnt;
        n_hi    = r_hi;
        n_dig   = r_dig;
        n_sum   = r_sum;
        n_err   = r_err;
        wr_en   = 1'b0;
        if (r_phase == PH_HUNT) begin
            if (cls.is_start) begin
                n_phase = PH_ID;
                n_len   = LEN_W'(1);
                n_id    = '0;
                n_cnt   = '0;
                n_hi    = '0;
                n_dig   = '0;
                n_sum   = '0;
                n_err   = ST_OK;
            end
        end else if (ends) begin
            n_phase = PH_HUNT;
            n_len   = '0;
        end else begin
            n_len = r_len + LEN_W'(1);
            if (r_err == ST_OK) begin
                unique case (r_phase)
                    PH_ID: begin
                        if (!cls.is_hex) begin
                            n_err = ST_BAD_ID;
                        end else begin
                            n_id  = {r_id[11:0], cls.nib};
                            n_dig = r_dig + 2'd1;
                            if (r_dig == 2'd3) begin
                                n_sum   = r_sum + {r_id[3:0], cls.nib};
                                n_dig   = '0;
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (r_dig == 2'd0) begin
                            if (cls.is_sep) begin
                                n_phase = PH_CHK;
                            end else if (!cls.is_hex || r_cnt >= 4'(DATA_MAX)) begin
                                n_err = ST_BAD_DATA;
                            end else begin
                                n_hi  = cls.nib;
                                n_dig = 2'd1;
                            end
                        end else if (!cls.is_hex) begin
                            n_err = ST_BAD_DATA;
                        end else begin
                            wr_en = 1'b1;
                            n_cnt = r_cnt + 4'd1;
                            n_sum = r_sum + pair_byte;
                            n_dig = '0;
                        end
                    end
                    PH_CHK: begin
                        if (!cls.is_hex) begin
                            n_err = ST_BAD_CHK;
                        end else if (r_dig == 2'd0) begin
                            n_hi  = cls.nib;
                            n_dig = 2'd1;
                        end else begin
                            n_sum   = r_sum + pair_byte;
                            n_dig   = '0;
                            n_phase = PH_TAIL;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_data[r_cnt[2:0]] <= pair_byte & BYTE_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_len    <= '0;
            r_id     <= '0;
            r_cnt    <= '0;
            r_hi     <= '0;
            r_dig    <= '0;
            r_sum    <= '0;
            r_err    <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_id    <= n_id;
                r_cnt   <= n_cnt;
                r_hi    <= n_hi;
                r_dig   <= n_dig;
                r_sum   <= n_sum;
                r_err   <= n_err;
            end
            if (accept && ends) begin
                r_ovalid <= 1'b1;
                r_ostat  <= end_stat;
                r_oid    <= (end_stat == ST_OK) ? r_id : '0;
                r_ocnt   <= (end_stat == ST_OK) ? r_cnt : '0;
                for (int k = 0; k < DATA_MAX; k++) begin
                    r_odata[k] <= ((end_stat == ST_OK) && (4'(k) < r_cnt)) ? r_data[k] : '0;
                end
            end else if (!i_frame_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_frame_valid = r_ovalid;
    assign o_frame_id    = r_oid;
    assign o_byte_count  = r_ocnt;
    assign o_status      = r_ostat;
    assign o_data_0      = r_odata[0];
    assign o_data_1      = r_odata[1];
    assign o_data_2      = r_odata[2];
    assign o_data_3      = r_odata[3];
    assign o_data_4      = r_odata[4];
    assign o_data_5      = r_odata[5];
    assign o_data_6      = r_odata[6];
    assign o_data_7      = r_odata[7];

`ifndef SYNTHESIS
    a_fail_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_ostat != ST_OK) |-> (r_oid == '0) && (r_ocnt == '0))
        else $error("failed frame carries id or count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(DATA_MAX))
        else $error("data count beyond limit");

    a_hunt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_len == '0))
        else $error("length count live while hunting");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ends |=> r_ovalid && (r_phase == PH_HUNT))
        else $error("frame end did not produce a result");
`endif

endmodule

/* rtl/ahcfp_char_dec.sv */
// Character classifier: strict hex digit decode and frame delimiter detect.
module ahcfp_char_dec (
    input  logic [7:0]     i_char,
    output ahcfp_pkg::t_char o_cls
);
    import ahcfp_pkg::*;

    always_comb begin
        o_cls          = '0;
        o_cls.is_start = (i_char == CH_START);
        o_cls.is_end   = (i_char == CH_END);
        o_cls.is_sep   = (i_char == CH_SEP);
        if (i_char >= 8'h30 && i_char <= 8'h39) begin
            o_cls.is_hex = 1'b1;
            o_cls.nib    = 4'(i_char - 8'h30);
        end else if (i_char >= 8'h41 && i_char <= 8'h46) begin
            o_cls.is_hex = 1'b1;
            o_cls.nib    = 4'(i_char - 8'h37);
        end else if (i_char >= 8'h61 && i_char <= 8'h66) begin
            o_cls.is_hex = 1'b1;
            o_cls.nib    = 4'(i_char - 8'h57);
        end
    end

endmodule
